### src/sce_pkg.sv
// Shared constants, types and exp tables for the softmax cross-entropy row block.
// No dependencies.
`default_nettype none
package sce_pkg;
    localparam int MaxClassesDefault = 64;
    localparam int LogitW = 16;
    localparam int LabelW = 6;
    localparam int ProbW = 17;
    localparam int GradW = 18;
    localparam int CountW = 7;
    localparam int BatchW = 16;
    localparam int SumW = 27;
    localparam logic [0:0] RegClassCount = 1'b0;
    localparam logic [0:0] RegBatchSize = 1'b1;

    typedef struct packed {
        logic load;      // store one logit word
        logic first;     // first word of the row
        logic clr_row;   // reset row state
        logic exp_issue; // read one stored logit for exp
        logic exp_acc;   // accumulate exp result
        logic div_start; // start divide for one class
        logic grad_start;
        logic emit;
    } sce_cmd_t;

    typedef struct packed {
        logic div_done;
        logic grad_done;
    } sce_sts_t;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        case (n)
            4'd0: exp_int = 17'd65536;
            4'd1: exp_int = 17'd24109;
            4'd2: exp_int = 17'd8869;
            4'd3: exp_int = 17'd3263;
            4'd4: exp_int = 17'd1200;
            4'd5: exp_int = 17'd442;
            4'd6: exp_int = 17'd162;
            4'd7: exp_int = 17'd60;
            4'd8: exp_int = 17'd22;
            4'd9: exp_int = 17'd8;
            4'd10: exp_int = 17'd3;
            4'd11: exp_int = 17'd1;
            default: exp_int = 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        case (h)
            4'd0: exp_hi = 17'd65536;
            4'd1: exp_hi = 17'd61565;
            4'd2: exp_hi = 17'd57835;
            4'd3: exp_hi = 17'd54331;
            4'd4: exp_hi = 17'd51039;
            4'd5: exp_hi = 17'd47947;
            4'd6: exp_hi = 17'd45042;
            4'd7: exp_hi = 17'd42313;
            4'd8: exp_hi = 17'd39750;
            4'd9: exp_hi = 17'd37341;
            4'd10: exp_hi = 17'd35079;
            4'd11: exp_hi = 17'd32954;
            4'd12: exp_hi = 17'd30957;
            4'd13: exp_hi = 17'd29081;
            4'd14: exp_hi = 17'd27319;
            default: exp_hi = 17'd25664;
        endcase
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        case (l)
            4'd0: exp_lo = 17'd65536;
            4'd1: exp_lo = 17'd65280;
            4'd2: exp_lo = 17'd65026;
            4'd3: exp_lo = 17'd64772;
            4'd4: exp_lo = 17'd64520;
            4'd5: exp_lo = 17'd64268;
            4'd6: exp_lo = 17'd64018;
            4'd7: exp_lo = 17'd63768;
            4'd8: exp_lo = 17'd63520;
            4'd9: exp_lo = 17'd63272;
            4'd10: exp_lo = 17'd63025;
            4'd11: exp_lo = 17'd62780;
            4'd12: exp_lo = 17'd62535;
            4'd13: exp_lo = 17'd62291;
            4'd14: exp_lo = 17'd62048;
            default: exp_lo = 17'd61806;
        endcase
    endfunction
endpackage
`default_nettype wire

### src/sce_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Does not use sce_pkg; self-contained.
`default_nettype none
module sce_divider #(
    parameter int NumW = 44,
    parameter int DenW = 27
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NumW-1:0] numer,
    input  wire logic [DenW-1:0] denom,
    output logic                 done,
    output logic [NumW-1:0]      quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] q_reg;
    logic [DenW:0]   r_reg;
    logic [DenW-1:0] d_reg;
    logic [CntW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [DenW:0]   trial;
    logic            ge;

    always_comb
    begin
        trial = {r_reg[DenW-1:0], q_reg[NumW-1]};
        ge = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CntW'(NumW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= numer;
            r_reg <= '0;
            d_reg <= denom;
        end
        else if (run_reg)
        begin
            q_reg <= {q_reg[NumW-2:0], ge};
            r_reg <= ge ? trial - {1'b0, d_reg} : trial;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

### src/sce_datapath.sv
// Datapath: logit and exp memories, running max, pipelined exp, dividers, result register.
// Depends on sce_pkg and sce_divider.
`default_nettype none
module sce_datapath
    import sce_pkg::*;
#(
    parameter int MaxClasses = MaxClassesDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sce_cmd_t                      cmd,
    input  wire logic [$clog2(MaxClasses)-1:0] wr_idx,
    input  wire logic [$clog2(MaxClasses)-1:0] rd_idx,
    input  wire logic [$clog2(MaxClasses)-1:0] acc_idx,
    input  wire logic                          last_res,
    input  wire logic [CountW-1:0]             res_count,
    input  wire logic signed [LogitW-1:0]      logit,
    input  wire logic [LabelW-1:0]             class_label,
    input  wire logic [BatchW-1:0]             batch_size,
    output sce_sts_t                           sts,
    output logic                               valid,
    output logic [LabelW-1:0]                  class_index,
    output logic [ProbW-1:0]                   probability,
    output logic signed [GradW-1:0]            gradient,
    output logic                               last_of_row
);
    localparam int IdxW = $clog2(MaxClasses);
    localparam int ResW = $clog2(MaxClasses + 1);

    logic signed [LogitW-1:0] logit_mem [MaxClasses];
    logic [ProbW-1:0]         exp_mem [MaxClasses];
    logic signed [LogitW-1:0] max_reg;
    logic [SumW-1:0]          sum_reg;
    logic [LabelW-1:0]        label_reg;

    logic signed [LogitW-1:0] rd_logit_reg;
    logic [15:0]              t_reg;
    logic [16:0]              lo_reg;
    logic                     zero_reg;
    logic [33:0]              e1_prod_reg;
    logic [16:0]              e1;
    logic [33:0]              e2_prod;
    logic [ProbW-1:0]         e_val;
    logic [16:0]              e_rd_reg;
    logic [IdxW-1:0]          k_reg;

    // exp path: read, subtract, first multiply, second multiply (combined into store)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            logit_mem[wr_idx] <= logit;
        rd_logit_reg <= logit_mem[rd_idx];
        t_reg <= 16'(32'(max_reg) - 32'(rd_logit_reg));
        e1_prod_reg <= 34'(exp_int(t_reg[15:8] > 8'd11 ? 4'd12 : t_reg[11:8]))
                     * 34'(exp_hi(t_reg[7:4]));
        lo_reg <= exp_lo(t_reg[3:0]);
        zero_reg <= t_reg[15:8] > 8'd11;
        if (cmd.exp_acc)
            exp_mem[acc_idx] <= e_val;
        e_rd_reg <= exp_mem[rd_idx];
    end

    always_comb
    begin
        e1 = 17'((e1_prod_reg + 34'd32768) >> 16);
        e2_prod = 34'(e1) * 34'(lo_reg);
        e_val = zero_reg ? '0 : ProbW'((e2_prod + 34'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 16'sh8000;
            sum_reg <= '0;
            label_reg <= '0;
        end
        else
        begin
            if (cmd.clr_row)
            begin
                max_reg <= 16'sh8000;
                sum_reg <= '0;
            end
            else
            begin
                if (cmd.load && logit > max_reg)
                    max_reg <= logit;
                if (cmd.exp_acc)
                    sum_reg <= sum_reg + SumW'(e_val);
            end
            if (cmd.load && cmd.first)
                label_reg <= class_label;
        end
    end

    // probability divide
    logic [43:0] p_num;
    logic [43:0] p_quot;
    logic        p_done;
    assign p_num = 44'({e_rd_reg, 16'd0}) + 44'(sum_reg >> 1);
    sce_divider #(.NumW(44), .DenW(SumW)) u_pdiv (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .numer(p_num),
        .denom(sum_reg), .done(p_done), .quot(p_quot));

    logic [ProbW-1:0] p_reg;
    logic             is_lab_reg;
    logic             is_lab;
    assign is_lab = ResW'(k_reg) == ResW'(label_reg)
                    && 32'(label_reg) < 32'(res_count);
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            k_reg <= rd_idx;
        if (p_done)
        begin
            p_reg <= ProbW'(p_quot);
            is_lab_reg <= is_lab;
        end
    end

    // gradient divide, started straight from the probability quotient
    logic [16:0] g_num;
    logic [16:0] g_quot;
    logic        g_done;
    logic [15:0] bs;
    assign bs = (batch_size == '0) ? 16'd1 : batch_size;
    assign g_num = is_lab ? 17'(18'd65536 - 18'(p_quot[ProbW-1:0])) : p_quot[ProbW-1:0];
    sce_divider #(.NumW(17), .DenW(BatchW)) u_gdiv (
        .clk(clk), .rst_n(rst_n), .start(cmd.grad_start), .numer(g_num),
        .denom(bs), .done(g_done), .quot(g_quot));

    logic valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            class_index <= LabelW'(k_reg);
            probability <= p_reg;
            gradient <= is_lab_reg ? GradW'(GradW'(0) - GradW'(g_quot)) : GradW'(g_quot);
            last_of_row <= last_res;
        end
    end

    assign valid = valid_reg;
    assign sts.div_done = p_done;
    assign sts.grad_done = g_done;
endmodule
`default_nettype wire

### src/sce_ctrl.sv
// Controller state machine: row loading, exp sweep, per-class divide and emit.
// Depends on sce_pkg.
`default_nettype none
module sce_ctrl
    import sce_pkg::*;
#(
    parameter int MaxClasses = MaxClassesDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [CountW-1:0]             class_count,
    input  wire sce_sts_t                      sts,
    output logic                               busy,
    output sce_cmd_t                           cmd,
    output logic [$clog2(MaxClasses)-1:0]      wr_idx,
    output logic [$clog2(MaxClasses)-1:0]      rd_idx,
    output logic [$clog2(MaxClasses)-1:0]      acc_idx,
    output logic                               last_res,
    output logic [CountW-1:0]                  res_count
);
    localparam int IdxW = $clog2(MaxClasses);
    localparam int CntW = $clog2(MaxClasses + 1);
    localparam int ExpLat = 3;

    typedef enum logic [2:0] {S_LOAD, S_EXP, S_DRAIN, S_RD, S_DIV, S_GRAD, S_EMIT}
        state_t;

    state_t state_reg;
    logic [CntW-1:0] cnt_reg;   // elements received
    logic [CntW-1:0] m_reg;     // row length
    logic [CntW-1:0] rd_reg;
    logic [CntW-1:0] acc_reg;
    logic [ExpLat-1:0] pipe_reg;
    logic [CntW-1:0] row_len;
    logic [CntW-1:0] idx;
    logic accept;

    always_comb
    begin
        row_len = (class_count == '0) ? CntW'(1)
                : (32'(class_count) > MaxClasses) ? CntW'(MaxClasses) : CntW'(class_count);
        idx = (32'(cnt_reg) >= MaxClasses) ? CntW'(MaxClasses - 1) : cnt_reg;
        accept = start && state_reg == S_LOAD;
        busy = state_reg != S_LOAD;
        cmd = '0;
        cmd.load = accept;
        cmd.first = idx == '0;
        cmd.exp_issue = state_reg == S_EXP;
        cmd.exp_acc = pipe_reg[ExpLat-1];
        cmd.clr_row = state_reg == S_EMIT && rd_reg + 1'b1 == m_reg;
        cmd.div_start = state_reg == S_RD;
        cmd.grad_start = state_reg == S_DIV && sts.div_done;
        cmd.emit = state_reg == S_GRAD && sts.grad_done;
        wr_idx = IdxW'(idx);
        // prefetch the next class's exp while the current word goes out
        rd_idx = IdxW'((state_reg == S_EMIT) ? rd_reg + 1'b1 : rd_reg);
        acc_idx = IdxW'(acc_reg);
        last_res = rd_reg + 1'b1 == m_reg;
        res_count = CountW'(m_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            m_reg <= '0;
            rd_reg <= '0;
            acc_reg <= '0;
            pipe_reg <= '0;
        end
        else
        begin
            pipe_reg <= {pipe_reg[ExpLat-2:0], state_reg == S_EXP};
            if (pipe_reg[ExpLat-1])
                acc_reg <= acc_reg + 1'b1;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (idx + 1'b1 < row_len)
                            cnt_reg <= idx + 1'b1;
                        else
                        begin
                            m_reg <= idx + 1'b1;
                            rd_reg <= '0;
                            acc_reg <= '0;
                            state_reg <= S_EXP;
                        end
                    end
                end
                S_EXP:
                begin
                    rd_reg <= rd_reg + 1'b1;
                    if (rd_reg + 1'b1 == m_reg)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    rd_reg <= '0;
                    if (pipe_reg == '0)
                        state_reg <= S_RD;
                end
                S_RD: state_reg <= S_DIV;
                S_DIV: if (sts.div_done) state_reg <= S_GRAD;
                S_GRAD: if (sts.grad_done) state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (rd_reg + 1'b1 == m_reg)
                    begin
                        rd_reg <= rd_reg + 1'b1;
                        cnt_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        rd_reg <= rd_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_acc_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> acc_reg == m_reg) else $error("exp sweep incomplete");
    a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.div_start) else $error("divide restarted");
    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_EMIT) else $error("emit out of order");
`endif
endmodule
`default_nettype wire

### src/softmax_cross_entropy_row.sv
// Top level of the softmax cross-entropy row block.
// Depends on sce_pkg, sce_ctrl and sce_datapath.
`default_nettype none
// Load one logit word per cycle while busy is low; the row ends on the word that
// reaches class_count. busy then rises: an exp pass reads every stored logit
// through a three-stage table pipeline, and each class then gets a start step,
// a probability divide and a gradient divide, both radix-2 serial units, and an
// emit step; the next row loads only once every class is out. Each result word
// shows on the result ports for one cycle with valid high; the receiver cannot
// stall, so capture it then.
module softmax_cross_entropy_row
    import sce_pkg::*;
#(
    parameter int MaxClasses = MaxClassesDefault
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [LogitW-1:0] logit,
    input  wire logic [LabelW-1:0]        class_label,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [BatchW-1:0]        cfg_data,
    output logic                          valid,
    output logic [LabelW-1:0]             class_index,
    output logic [ProbW-1:0]              probability,
    output logic signed [GradW-1:0]       gradient,
    output logic                          last_of_row
);
    localparam int IdxW = $clog2(MaxClasses);

    logic [CountW-1:0] class_count_reg;
    logic [BatchW-1:0] batch_size_reg;

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= CountW'(64);
            batch_size_reg <= BatchW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegClassCount: class_count_reg <= cfg_data[CountW-1:0];
                RegBatchSize: batch_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sce_cmd_t cmd;
    sce_sts_t sts;
    logic [IdxW-1:0] wr_idx, rd_idx, acc_idx;
    logic last_res;
    logic [CountW-1:0] res_count;

    sce_ctrl #(.MaxClasses(MaxClasses)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .class_count(class_count_reg),
        .sts(sts), .busy(busy), .cmd(cmd), .wr_idx(wr_idx), .rd_idx(rd_idx),
        .acc_idx(acc_idx), .last_res(last_res), .res_count(res_count));

    sce_datapath #(.MaxClasses(MaxClasses)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .wr_idx(wr_idx), .rd_idx(rd_idx),
        .acc_idx(acc_idx), .last_res(last_res), .res_count(res_count),
        .logit(logit), .class_label(class_label), .batch_size(batch_size_reg),
        .sts(sts), .valid(valid), .class_index(class_index),
        .probability(probability), .gradient(gradient), .last_of_row(last_of_row));
endmodule
`default_nettype wire

### sim/tb_softmax_cross_entropy_row.sv
// Self-checking testbench for softmax_cross_entropy_row: directed rows, register extremes,
// a mid-row shrink and random rows, each checked word by word against an in-bench predictor.
// Depends on sce_pkg and the softmax_cross_entropy_row RTL.
module tb_softmax_cross_entropy_row;
    import sce_pkg::*;

    typedef struct packed {
        logic [LabelW-1:0]       cls;
        logic [ProbW-1:0]        prob;
        logic signed [GradW-1:0] grad;
        logic                    last;
    } class_word_t;

    localparam int StallLimit = 5000;

    // exp(-n), exp(-h/16) and exp(-l/256) in Q1.16
    localparam int unsigned ExpIntTab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                                22, 8, 3, 1};
    localparam int unsigned ExpHiTab [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                               42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                               27319, 25664};
    localparam int unsigned ExpLoTab [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                               63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                               62048, 61806};

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [LogitW-1:0] logit;
    logic [LabelW-1:0]        class_label;
    logic                     cfg_we;
    logic [0:0]               cfg_index;
    logic [BatchW-1:0]        cfg_data;
    logic                     valid;
    logic [LabelW-1:0]        class_index;
    logic [ProbW-1:0]         probability;
    logic signed [GradW-1:0]  gradient;
    logic                     last_of_row;

    softmax_cross_entropy_row dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .logit       (logit),
        .class_label (class_label),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .valid       (valid),
        .class_index (class_index),
        .probability (probability),
        .gradient    (gradient),
        .last_of_row (last_of_row)
    );

    // Predictor state: a mirror of the block's registers and row store
    logic [CountW-1:0]        class_count_q;
    logic [BatchW-1:0]        batch_size_q;
    logic signed [LogitW-1:0] row_logits [MaxClassesDefault];
    logic signed [LogitW-1:0] row_max;
    int unsigned              row_fill;
    logic [LabelW-1:0]        row_label_q;

    class_word_t pending_words[$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          rows_done;
    bit          idle_on;
    int          stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int unsigned table_exp(input int unsigned t);
        longint unsigned e;
        if ((t >> 8) >= 12)
            return 0;
        e = (longint'(ExpIntTab[t >> 8]) * ExpHiTab[(t >> 4) & 15] + 32768) >> 16;
        e = (e * ExpLoTab[t & 15] + 32768) >> 16;
        return int'(e);
    endfunction

    // Absorb one accepted logit; at row end queue one expected word per class
    task automatic predict_softmax_row(input logic signed [LogitW-1:0] x,
                                       input logic [LabelW-1:0] lbl);
        int unsigned     row_len;
        int unsigned     slot;
        int unsigned     exps [MaxClassesDefault];
        int unsigned     sum;
        int unsigned     bs;
        longint unsigned p;
        longint unsigned q;
        class_word_t     w;
        row_len = class_count_q;
        if (row_len < 1)
            row_len = 1;
        if (row_len > MaxClassesDefault)
            row_len = MaxClassesDefault;
        slot = (row_fill >= MaxClassesDefault) ? MaxClassesDefault - 1 : row_fill;
        if (slot == 0)
            row_label_q = lbl;
        row_logits[slot] = x;
        if (x > row_max)
            row_max = x;
        if (slot + 1 < row_len)
        begin
            row_fill = slot + 1;
            return;
        end
        sum = 0;
        for (int k = 0; k <= slot; k++)
        begin
            exps[k] = table_exp(int'(row_max) - int'(row_logits[k]));
            sum += exps[k];
        end
        bs = (batch_size_q == 0) ? 1 : batch_size_q;
        for (int k = 0; k <= slot; k++)
        begin
            p = (longint'(exps[k]) * 65536 + sum / 2) / sum;
            w.cls = k[LabelW-1:0];
            w.prob = p[ProbW-1:0];
            if (k == row_label_q)
            begin
                q = (65536 - p) / bs;
                w.grad = -$signed({1'b0, q[GradW-2:0]});
            end
            else
                w.grad = GradW'(p / bs);
            w.last = (k == slot);
            pending_words.push_back(w);
        end
        row_max = -16'sd32768;
        row_fill = 0;
        rows_done++;
    endtask

    // Check every result word against the oldest expectation
    always @(posedge clk)
    begin
        if (valid)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word for class %0d", class_index));
            else
            begin
                class_word_t w;
                w = pending_words.pop_front();
                words_checked++;
                if (class_index !== w.cls)
                    report_mismatch($sformatf("class_index %0d, want %0d", class_index, w.cls));
                if (probability !== w.prob)
                    report_mismatch($sformatf("class %0d probability %0d, want %0d",
                                              w.cls, probability, w.prob));
                if (gradient !== w.grad)
                    report_mismatch($sformatf("class %0d gradient %0d, want %0d",
                                              w.cls, gradient, w.grad));
                if (last_of_row !== w.last)
                    report_mismatch($sformatf("class %0d last_of_row %0b, want %0b",
                                              w.cls, last_of_row, w.last));
            end
        end
    end

    // Watchdog: count cycles in which neither a logit nor a result word moves
    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("watchdog expired at %0t", $time);
            $display("status: fail");
            $finish;
        end
    end

    // Send one logit word; entered and left at a falling edge, start left high
    task automatic send_logit(input logic signed [LogitW-1:0] x, input logic [LabelW-1:0] lbl);
        if (idle_on && $urandom_range(99) < 38)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        start = 1'b1;
        logit = x;
        class_label = lbl;
        do
            @(posedge clk);
        while (busy);
        predict_softmax_row(x, lbl);
        words_sent++;
        @(negedge clk);
    endtask

    // Hold off until all results are in and the block has settled, then write
    task automatic write_reg(input logic [0:0] idx, input logic [BatchW-1:0] value);
        start = 1'b0;
        wait (pending_words.size() == 0);
        @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == RegClassCount)
            class_count_q = value[CountW-1:0];
        else
            batch_size_q = value;
    endtask

    task automatic send_row(input int len, input logic [LabelW-1:0] lbl, input bit clustered);
        logic signed [LogitW-1:0] base;
        base = LogitW'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (clustered)
                send_logit(base + $signed({1'b0, 15'($urandom_range(2047))}),
                           LabelW'($urandom));
            else
                send_logit(LogitW'($urandom), (i == 0) ? lbl : LabelW'($urandom));
        end
    endtask

    // Field extremes, equal logits, a spread beyond the table and an out-of-row label
    task automatic test_directed_rows();
        write_reg(RegClassCount, 16'd4);
        send_logit(16'sh7FFF, 6'd0);
        send_logit(-16'sh8000, 6'd63);
        send_logit(16'sd0, 6'd1);
        send_logit(16'sd1, 6'd2);
        send_logit(16'sd256, 6'd3);
        send_logit(16'sd256, 6'd0);
        send_logit(16'sd255, 6'd0);
        send_logit(16'sd240, 6'd0);
        write_reg(RegClassCount, 16'd3);
        send_logit(16'sd100, 6'd63);
        send_logit(16'sd100, 6'd0);
        send_logit(-16'sd100, 6'd0);
        write_reg(RegClassCount, 16'd1);
        send_logit(16'sh5555, 6'd0);
        send_logit(-16'sh2AAB, 6'd5);
    endtask

    // Both registers at their extremes, zero values acting as one, the widest row
    task automatic test_register_extremes();
        write_reg(RegClassCount, 16'd0);
        write_reg(RegBatchSize, 16'd0);
        send_logit(16'sd7, 6'd0);
        write_reg(RegBatchSize, 16'hFFFF);
        write_reg(RegClassCount, 16'd2);
        send_logit(16'sd0, 6'd1);
        send_logit(16'sd0, 6'd0);
        write_reg(RegBatchSize, 16'd3);
        write_reg(RegClassCount, 16'h7F);
        send_row(64, 6'd63, 1'b1);
        write_reg(RegClassCount, 16'd64);
        write_reg(RegBatchSize, 16'd1);
        send_row(64, 6'd17, 1'b0);
    endtask

    // Shrink class_count part way through a row; the next word closes it
    task automatic test_mid_row_shrink();
        write_reg(RegClassCount, 16'd10);
        for (int i = 0; i < 5; i++)
            send_logit(16'(i * 37), 6'(4 - i));
        write_reg(RegClassCount, 16'd3);
        send_logit(16'sd64, 6'd9);
    endtask

    task automatic test_random_rows();
        int len;
        while (words_sent < 250)
        begin
            if ($urandom_range(19) == 0)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(1, 8);
            // drop the idling for a long middle stretch
            idle_on = !(words_sent > 160 && words_sent < 230);
            write_reg(RegClassCount, 16'(len));
            write_reg(RegBatchSize, ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1, 9)));
            send_row(len, ($urandom_range(3) == 0) ? 6'($urandom_range(len, 63))
                                                   : 6'($urandom_range(len - 1)),
                     $urandom_range(1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        logit = '0;
        class_label = '0;
        cfg_we = 1'b0;
        cfg_index = RegClassCount;
        cfg_data = '0;
        class_count_q = 7'd64;
        batch_size_q = 16'd1;
        row_max = -16'sh8000;
        row_fill = 0;
        row_label_q = '0;
        foreach (row_logits[i])
            row_logits[i] = '0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        rows_done = 0;
        idle_on = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_rows();
        test_register_extremes();
        test_mid_row_shrink();
        test_random_rows();

        start = 1'b0;
        wait (pending_words.size() == 0);
        repeat (20) @(negedge clk);
        $display("covered %0d logit words in %0d rows, %0d result words checked",
                 words_sent, rows_done, words_checked);
        $display("rows from 1 to 64 classes, batch sizes 0 to 65535, mid-row shrink");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### softmax_cross_entropy_row.f
src/sce_pkg.sv
src/sce_divider.sv
src/sce_datapath.sv
src/sce_ctrl.sv
src/softmax_cross_entropy_row.sv
sim/tb_softmax_cross_entropy_row.sv
